// ===== hw/rtl/multilevel_queue_slot_scheduler_defines.svh =====
// Assertion macros for the multilevel queue slot scheduler.
`ifndef MULTILEVEL_QUEUE_SLOT_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_QUEUE_SLOT_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define MLQS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlqs: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MLQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlqs: next-cycle check failed");

`else

`define MLQS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MLQS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/mlqs_pkg.sv =====
package mlqs_pkg;

  localparam logic KIND_ENQUEUE  = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  localparam logic [1:0] ST_ENQUEUED   = 2'd0;
  localparam logic [1:0] ST_DROPPED    = 2'd1;
  localparam logic [1:0] ST_DISPATCHED = 2'd2;
  localparam logic [1:0] ST_NONE       = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [15:0] task_id;
    logic [2:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] task_out;
    logic [2:0]  level_out;
  } out_item_t;

endpackage

// ===== hw/rtl/mlqs_ram.sv =====
module mlqs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mlqs_level_table.sv =====
module mlqs_level_table #(
  parameter int NUM_PRIO    = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    re,
  input  logic [$clog2(NUM_PRIO)-1:0]             raddr,
  output logic [$clog2(NUM_PRIO+1)+$clog2(QUEUE_DEPTH+1)
                + 2*$clog2(QUEUE_DEPTH)-1:0]      rdata,
  input  logic                                    we,
  input  logic [$clog2(NUM_PRIO)-1:0]             waddr,
  input  logic [$clog2(NUM_PRIO+1)+$clog2(QUEUE_DEPTH+1)
                + 2*$clog2(QUEUE_DEPTH)-1:0]      wdata
);

  localparam int LW = $clog2(NUM_PRIO);
  localparam int QW = $clog2(NUM_PRIO + 1);
  localparam int EW = QW + $clog2(QUEUE_DEPTH + 1) + 2 * $clog2(QUEUE_DEPTH);

  logic [NUM_PRIO-1:0] valid;
  logic                rd_valid;
  logic [LW-1:0]       rd_idx;
  logic [EW-1:0]       ram_q;
  logic [QW-1:0]       reset_quota;

  mlqs_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_PRIO)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(ram_q)
  );

  // A level never written since reset reads as empty with a full quota.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_valid <= valid[raddr];
      rd_idx   <= raddr;
    end
  end

  assign reset_quota = QW'(NUM_PRIO) - QW'(rd_idx);
  assign rdata = rd_valid ? ram_q : {reset_quota, (EW - QW)'(0)};

endmodule

// ===== hw/rtl/multilevel_queue_slot_scheduler.sv =====
// Multilevel queue slot scheduler. One transaction is accepted when start is
// high and busy is low; its single result appears on result for exactly one
// cycle with done high, and the receiver cannot stall it. An enqueue passes
// through S_ENQ before its result is registered; one to a level of NUM_PRIO
// or above is dropped, its result registered in the cycle after acceptance.
// A dispatch reads one level's state per cycle through the read port of the
// level table, starting at the rotating pointer, until a level holds a task,
// which S_FETCH then reads from the task store. Busy stays high until the
// result has been registered. No clearing pass is needed after reset.
`include "multilevel_queue_slot_scheduler_defines.svh"

module multilevel_queue_slot_scheduler #(
  parameter int NUM_PRIO    = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mlqs_pkg::in_item_t  item,
  output logic                done,
  output mlqs_pkg::out_item_t result
);

  localparam int LW = $clog2(NUM_PRIO);
  localparam int QW = $clog2(NUM_PRIO + 1);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int EW = QW + FW + 2 * PW;
  localparam int SD = NUM_PRIO * QUEUE_DEPTH;
  localparam int AW = $clog2(SD);

  typedef struct packed {
    logic [QW-1:0] quota;
    logic [FW-1:0] fill;
    logic [PW-1:0] tail;
    logic [PW-1:0] head;
  } lvl_entry_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ENQ   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FETCH = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [LW-1:0]       cur_lvl, cur_lvl_next;
  logic [LW-1:0]       scan_cnt, scan_cnt_next;
  logic [LW-1:0]       start_level, start_level_next;
  logic [15:0]         task_q, task_q_next;
  logic                done_next;
  mlqs_pkg::out_item_t result_next;

  logic                lvl_re, lvl_we;
  logic [LW-1:0]       lvl_raddr;
  logic [EW-1:0]       lvl_rdata;
  lvl_entry_t          ent, ent_upd;

  logic                st_we, st_re;
  logic [AW-1:0]       st_waddr, st_raddr;
  logic [15:0]         st_rdata;

  function automatic logic [AW-1:0] store_addr(input logic [LW-1:0] l,
                                               input logic [PW-1:0] p);
    return AW'(AW'(l) * AW'(QUEUE_DEPTH)) + AW'(p);
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [LW-1:0] lvl_inc(input logic [LW-1:0] l);
    return (l == LW'(NUM_PRIO - 1)) ? '0 : l + LW'(1);
  endfunction

  mlqs_level_table #(
    .NUM_PRIO   (NUM_PRIO),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_level_table (
    .clk  (clk),
    .rst  (rst),
    .re   (lvl_re),
    .raddr(lvl_raddr),
    .rdata(lvl_rdata),
    .we   (lvl_we),
    .waddr(cur_lvl),
    .wdata(ent_upd)
  );

  mlqs_ram #(
    .WIDTH(16),
    .DEPTH(SD)
  ) u_task_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(task_q),
    .re   (st_re),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  assign ent  = lvl_entry_t'(lvl_rdata);
  assign busy = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    cur_lvl_next     = cur_lvl;
    scan_cnt_next    = scan_cnt;
    start_level_next = start_level;
    task_q_next      = task_q;
    done_next        = 1'b0;
    result_next      = result;
    lvl_re           = 1'b0;
    lvl_raddr        = start_level;
    lvl_we           = 1'b0;
    ent_upd          = ent;
    st_we            = 1'b0;
    st_waddr         = store_addr(cur_lvl, ent.tail);
    st_re            = 1'b0;
    st_raddr         = store_addr(cur_lvl, ent.head);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          task_q_next = item.task_id;
          if (item.kind == mlqs_pkg::KIND_ENQUEUE) begin
            if (32'(item.priority_req) >= NUM_PRIO) begin
              done_next   = 1'b1;
              result_next = '{status: mlqs_pkg::ST_DROPPED, task_out: 16'd0,
                              level_out: 3'd0};
            end else begin
              lvl_re       = 1'b1;
              lvl_raddr    = LW'(item.priority_req);
              cur_lvl_next = LW'(item.priority_req);
              state_next   = S_ENQ;
            end
          end else begin
            lvl_re        = 1'b1;
            lvl_raddr     = start_level;
            cur_lvl_next  = start_level;
            scan_cnt_next = '0;
            state_next    = S_SCAN;
          end
        end
      end

      S_ENQ: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (ent.fill >= FW'(QUEUE_DEPTH)) begin
          result_next = '{status: mlqs_pkg::ST_DROPPED, task_out: 16'd0,
                          level_out: 3'd0};
        end else begin
          st_we        = 1'b1;
          lvl_we       = 1'b1;
          ent_upd.tail = ptr_inc(ent.tail);
          ent_upd.fill = ent.fill + FW'(1);
          result_next  = '{status: mlqs_pkg::ST_ENQUEUED, task_out: 16'd0,
                           level_out: 3'd0};
        end
      end

      S_SCAN: begin
        if (ent.fill != '0) begin
          // Quotas reload the moment they run out, so a held level always
          // has at least one slot left here.
          st_re        = 1'b1;
          lvl_we       = 1'b1;
          ent_upd.head = ptr_inc(ent.head);
          ent_upd.fill = ent.fill - FW'(1);
          if (ent.quota == QW'(1)) begin
            ent_upd.quota    = QW'(NUM_PRIO) - QW'(cur_lvl);
            start_level_next = lvl_inc(start_level);
          end else begin
            ent_upd.quota = ent.quota - QW'(1);
          end
          state_next = S_FETCH;
        end else if (scan_cnt == LW'(NUM_PRIO - 1)) begin
          done_next   = 1'b1;
          result_next = '{status: mlqs_pkg::ST_NONE, task_out: 16'd0,
                          level_out: 3'd0};
          state_next  = S_IDLE;
        end else begin
          lvl_re        = 1'b1;
          lvl_raddr     = lvl_inc(cur_lvl);
          cur_lvl_next  = lvl_inc(cur_lvl);
          scan_cnt_next = scan_cnt + LW'(1);
        end
      end

      S_FETCH: begin
        done_next   = 1'b1;
        result_next = '{status: mlqs_pkg::ST_DISPATCHED, task_out: st_rdata,
                        level_out: 3'(cur_lvl)};
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      start_level <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      start_level <= start_level_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_lvl  <= cur_lvl_next;
    scan_cnt <= scan_cnt_next;
    task_q   <= task_q_next;
    result   <= result_next;
  end

  `MLQS_ASSERT_NEXT(a_fetch_reports, clk, rst, state == S_FETCH, done && result.status == mlqs_pkg::ST_DISPATCHED)
  `MLQS_ASSERT_IMPLY(a_quota_live, clk, rst, state == S_SCAN && ent.fill != '0, ent.quota != '0)
  `MLQS_ASSERT_IMPLY(a_fill_bound, clk, rst, state == S_ENQ || state == S_SCAN, ent.fill <= FW'(QUEUE_DEPTH))
  `MLQS_ASSERT_NEXT(a_busy_no_accept, clk, rst, busy && !done, !(done && result.status == mlqs_pkg::ST_ENQUEUED && $past(state) == S_IDLE))

endmodule

// ===== verif/multilevel_queue_slot_scheduler_tb.sv =====
module multilevel_queue_slot_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PRIO    = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 925;
  localparam int BLOCK_LEN   = 60;
  localparam int CYCLE_LIMIT = 200000;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  mlqs_pkg::in_item_t  item;
  logic                done;
  mlqs_pkg::out_item_t result;

  multilevel_queue_slot_scheduler #(
    .NUM_PRIO   (NUM_PRIO),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  always #2 clk = ~clk;

  // Shadow of the scheduler state.
  logic [15:0] lvl_tasks [NUM_PRIO][QUEUE_DEPTH];
  int          lvl_head  [NUM_PRIO];
  int          lvl_tail  [NUM_PRIO];
  int          lvl_fill  [NUM_PRIO];
  int          lvl_quota [NUM_PRIO];
  int          scan_start;

  mlqs_pkg::out_item_t pending_outcomes[$];
  int                  error_count = 0;
  int                  cycle_count = 0;

  typedef struct {
    mlqs_pkg::in_item_t  it;
    bit                  typed;
    mlqs_pkg::out_item_t want;
  } stim_row_t;

  stim_row_t stim_rows[$];

  function automatic void clear_schedule();
    for (int l = 0; l < NUM_PRIO; l++) begin
      lvl_head[l]  = 0;
      lvl_tail[l]  = 0;
      lvl_fill[l]  = 0;
      lvl_quota[l] = NUM_PRIO - l;
    end
    scan_start = 0;
  endfunction

  function automatic void refill_quota(int lvl);
    lvl_quota[lvl] = NUM_PRIO - lvl;
    scan_start = (scan_start + 1) % NUM_PRIO;
  endfunction

  function automatic mlqs_pkg::out_item_t schedule_step(mlqs_pkg::in_item_t it);
    mlqs_pkg::out_item_t r;
    int                  lvl;
    r = '0;
    if (it.kind == mlqs_pkg::KIND_ENQUEUE) begin
      lvl = int'(it.priority_req);
      if (lvl >= NUM_PRIO || lvl_fill[lvl] >= QUEUE_DEPTH) begin
        r.status = mlqs_pkg::ST_DROPPED;
      end else begin
        lvl_tasks[lvl][lvl_tail[lvl]] = it.task_id;
        lvl_tail[lvl] = (lvl_tail[lvl] + 1) % QUEUE_DEPTH;
        lvl_fill[lvl]++;
        r.status = mlqs_pkg::ST_ENQUEUED;
      end
      return r;
    end
    for (int i = 0; i < NUM_PRIO; i++) begin
      lvl = (scan_start + i) % NUM_PRIO;
      if (lvl_fill[lvl] == 0) continue;
      if (lvl_quota[lvl] > 0) begin
        r.status    = mlqs_pkg::ST_DISPATCHED;
        r.task_out  = lvl_tasks[lvl][lvl_head[lvl]];
        r.level_out = lvl[2:0];
        lvl_head[lvl] = (lvl_head[lvl] + 1) % QUEUE_DEPTH;
        lvl_fill[lvl]--;
        lvl_quota[lvl]--;
        if (lvl_quota[lvl] == 0) refill_quota(lvl);
        return r;
      end
      refill_quota(lvl);
    end
    r.status = mlqs_pkg::ST_NONE;
    return r;
  endfunction

  function automatic void add_row(logic kind, logic [15:0] tid, logic [2:0] lvl,
                                  bit typed, logic [1:0] st, logic [15:0] tout,
                                  logic [2:0] lout);
    stim_row_t row;
    row.it.kind         = kind;
    row.it.task_id      = tid;
    row.it.priority_req = lvl;
    row.typed           = typed;
    row.want.status     = st;
    row.want.task_out   = tout;
    row.want.level_out  = lout;
    stim_rows.push_back(row);
  endfunction

  // Presents one transaction after an idle gap and returns at the edge that
  // accepts it, with the expected outcome queued.
  task automatic send_item(mlqs_pkg::in_item_t it, int gap, bit typed,
                           mlqs_pkg::out_item_t want);
    mlqs_pkg::out_item_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = schedule_step(it);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    mlqs_pkg::out_item_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected: status=%0d task=%h level=%0d",
                 $time, result.status, result.task_out, result.level_out);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   result.status);
          error_count++;
        end
        if (result.task_out !== want.task_out) begin
          $display("%0t: task_out expected %h actual %h", $time, want.task_out,
                   result.task_out);
          error_count++;
        end
        if (result.level_out !== want.level_out) begin
          $display("%0t: level_out expected %0d actual %0d", $time, want.level_out,
                   result.level_out);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mlqs_pkg::in_item_t  it;
    mlqs_pkg::out_item_t none;
    int                  enq_pct;
    bit                  focus;
    logic [2:0]          focus_lvl;
    bit                  no_idle;
    int                  gap;

    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    none  = '0;
    clear_schedule();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty scan, both ends of the id range and of the level range, then one
    // level filled past capacity, drained once and refilled across the tail wrap.
    add_row(mlqs_pkg::KIND_DISPATCH, 16'h0000, 3'd0, 1, mlqs_pkg::ST_NONE,
            16'h0000, 3'd0);
    add_row(mlqs_pkg::KIND_ENQUEUE, 16'h0000, 3'd0, 1, mlqs_pkg::ST_ENQUEUED,
            16'h0000, 3'd0);
    add_row(mlqs_pkg::KIND_ENQUEUE, 16'hFFFF, 3'd7, 1, mlqs_pkg::ST_ENQUEUED,
            16'h0000, 3'd0);
    add_row(mlqs_pkg::KIND_DISPATCH, 16'hFFFF, 3'd7, 1, mlqs_pkg::ST_DISPATCHED,
            16'h0000, 3'd0);
    add_row(mlqs_pkg::KIND_DISPATCH, 16'h0000, 3'd0, 1, mlqs_pkg::ST_DISPATCHED,
            16'hFFFF, 3'd7);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      add_row(mlqs_pkg::KIND_ENQUEUE, 16'(16'h3000 + i), 3'd3, 1,
              mlqs_pkg::ST_ENQUEUED, 16'h0000, 3'd0);
    add_row(mlqs_pkg::KIND_ENQUEUE, 16'hAAAA, 3'd3, 1, mlqs_pkg::ST_DROPPED,
            16'h0000, 3'd0);
    add_row(mlqs_pkg::KIND_DISPATCH, 16'h0000, 3'd0, 1, mlqs_pkg::ST_DISPATCHED,
            16'h3000, 3'd3);
    add_row(mlqs_pkg::KIND_ENQUEUE, 16'h5555, 3'd3, 0, mlqs_pkg::ST_ENQUEUED,
            16'h0000, 3'd0);
    add_row(mlqs_pkg::KIND_DISPATCH, 16'h0000, 3'd0, 0, mlqs_pkg::ST_NONE,
            16'h0000, 3'd0);
    add_row(mlqs_pkg::KIND_DISPATCH, 16'h0000, 3'd0, 0, mlqs_pkg::ST_NONE,
            16'h0000, 3'd0);

    foreach (stim_rows[r])
      send_item(stim_rows[r].it, $urandom_range(3), stim_rows[r].typed,
                stim_rows[r].want);

    enq_pct   = 50;
    focus     = 0;
    focus_lvl = '0;
    no_idle   = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Each block shifts the balance between filling and draining, so the
      // queues swing between empty and full.
      if (n % BLOCK_LEN == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 85;
          1: enq_pct = 50;
          default: enq_pct = 15;
        endcase
        focus     = ($urandom_range(9) < 3);
        focus_lvl = 3'($urandom_range(NUM_PRIO - 1));
        no_idle   = ($urandom_range(3) == 0);
      end
      if (n == RANDOM_ITEMS / 2) wait_drained();
      it.kind         = ($urandom_range(99) < enq_pct) ? mlqs_pkg::KIND_ENQUEUE :
                                                         mlqs_pkg::KIND_DISPATCH;
      it.task_id      = 16'($urandom);
      it.priority_req = focus ? focus_lvl : 3'($urandom_range(NUM_PRIO - 1));
      gap = no_idle ? 0 : $urandom_range(3);
      send_item(it, gap, 0, none);
    end

    wait_drained();
    repeat (NUM_PRIO + 4) @(posedge clk);
    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
